@@ src/quadrature_speed_capture_core_defines.svh @@
// Assertion macros shared by the quadrature speed capture RTL.
`ifndef QUADRATURE_SPEED_CAPTURE_CORE_DEFINES_SVH
`define QUADRATURE_SPEED_CAPTURE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/qsc_pkg.sv @@
// Types and constants shared by the quadrature speed capture block.
package qsc_pkg;

  localparam int unsigned WINDOW_EDGES = 32;
  localparam int unsigned EDGE_CNT_W   = 6;
  localparam logic [EDGE_CNT_W-1:0] WINDOW_EDGES_C = EDGE_CNT_W'(WINDOW_EDGES);
  localparam logic [4:0]  PERIOD_MASK      = 5'b11111;
  localparam logic [31:0] WRAP_CORRECTION  = 32'd536870912;

  typedef enum logic [1:0] {
    REQ_OVERFLOW = 2'd0,
    REQ_EDGE_A   = 2'd1,
    REQ_EDGE_B   = 2'd2,
    REQ_STATUS   = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] edge_timestamp;
    logic        level_a;
    logic        level_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0]     position;
    logic signed [31:0]     pulse_difference;
    logic [31:0]            current_time_sum;
    logic [31:0]            previous_time_sum;
    logic [EDGE_CNT_W-1:0]  edges_remaining;
    logic                   data_ready;
  } res_t;

endpackage

@@ src/qsc_if.sv @@
// Handshake channels of the quadrature speed capture block.
interface qsc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] edge_timestamp;
  logic        level_a;
  logic        level_b;

  modport source (output valid, req_type, edge_timestamp, level_a, level_b, input ready);
  modport sink (input valid, req_type, edge_timestamp, level_a, level_b, output ready);
endinterface

interface qsc_res_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] position;
  logic signed [31:0] pulse_difference;
  logic [31:0]       current_time_sum;
  logic [31:0]       previous_time_sum;
  logic [5:0]        edges_remaining;
  logic              data_ready;

  modport source (output valid, position, pulse_difference, current_time_sum,
                  previous_time_sum, edges_remaining, data_ready, input ready);
  modport sink (input valid, position, pulse_difference, current_time_sum,
                previous_time_sum, edges_remaining, data_ready, output ready);
endinterface

interface qsc_cfg_if;
  logic valid;
  logic ready;
  logic invert_direction;

  modport source (output valid, invert_direction, input ready);
  modport sink (input valid, invert_direction, output ready);
endinterface

@@ src/qsc_engine.sv @@
// Position, overflow and window timing state with its single-pass update logic.
module qsc_engine
  import qsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  req_t req_i,
  input  logic invert_i,
  output res_t result_o
);

  logic [7:0]            ovf_q, ovf_d;
  logic [31:0]           pos_q, pos_d;
  logic [31:0]           start_q, start_d;
  logic [31:0]           diff_q, diff_d;
  logic [EDGE_CNT_W-1:0] edges_q, edges_d;
  logic                  ready_q, ready_d;
  logic [31:0]           acc_q, acc_d;
  logic [31:0]           prev_q, prev_d;
  logic [7:0]            ovf_inc;
  logic [31:0]           acc_wrapped;
  logic                  chan_b;
  logic                  step_up;
  logic                  shown_ready;

  always_comb begin
    ovf_d   = ovf_q;
    pos_d   = pos_q;
    start_d = start_q;
    diff_d  = diff_q;
    edges_d = edges_q;
    ready_d = ready_q;
    acc_d   = acc_q;
    prev_d  = prev_q;

    ovf_inc     = ovf_q + 8'd1;
    acc_wrapped = (ovf_inc == 8'd0) ? (acc_q - WRAP_CORRECTION) : acc_q;
    chan_b      = (req_i.req_type == REQ_EDGE_B);
    step_up     = ((req_i.level_a == req_i.level_b) ? chan_b : !chan_b) ^ invert_i;

    case (req_i.req_type)
      REQ_OVERFLOW: begin
        ovf_d = ovf_inc;
        // A new window opens whenever the low five bits roll over.
        if ((ovf_inc[4:0] & PERIOD_MASK) == 5'd0) begin
          diff_d  = pos_q - start_q;
          start_d = pos_q;
          edges_d = WINDOW_EDGES_C;
          prev_d  = acc_wrapped;
          acc_d   = 32'd0;
        end
        // An unfinished window is abandoned one tick before the next opens.
        if ((ovf_inc[4:0] == PERIOD_MASK) && (edges_q != '0)) begin
          edges_d = '0;
          acc_d   = 32'd0;
          ready_d = 1'b1;
        end
      end
      REQ_EDGE_A, REQ_EDGE_B: begin
        if (edges_q != '0) begin
          acc_d   = acc_q + {8'd0, ovf_q, req_i.edge_timestamp};
          edges_d = edges_q - EDGE_CNT_W'(1);
          if (edges_q == EDGE_CNT_W'(1)) begin
            ready_d = 1'b1;
          end
        end
        pos_d = step_up ? (pos_q + 32'd1) : (pos_q - 32'd1);
      end
      REQ_STATUS: begin
        ready_d = 1'b0;
      end
      default: begin
        ready_d = ready_q;
      end
    endcase

    // A status read reports the flag as it stood before the read clears it.
    shown_ready = (req_i.req_type == REQ_STATUS) ? ready_q : ready_d;

    result_o.position          = $signed(pos_d);
    result_o.pulse_difference  = $signed(diff_d);
    result_o.current_time_sum  = acc_d;
    result_o.previous_time_sum = prev_d;
    result_o.edges_remaining   = edges_d;
    result_o.data_ready        = shown_ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q   <= '0;
      pos_q   <= '0;
      start_q <= '0;
      diff_q  <= '0;
      edges_q <= '0;
      ready_q <= 1'b0;
      acc_q   <= '0;
      prev_q  <= '0;
    end else if (step_i) begin
      ovf_q   <= ovf_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      diff_q  <= diff_d;
      edges_q <= edges_d;
      ready_q <= ready_d;
      acc_q   <= acc_d;
      prev_q  <= prev_d;
    end
  end

endmodule

@@ src/quadrature_speed_capture_core.sv @@
// Quadrature speed capture: top level with input register, engine and result register.
//
// Usage: words arrive on req_i (valid/ready) as timer overflow ticks, edges on
// channel A or B with a 16-bit timestamp and both pin levels, or status reads.
// Every accepted word produces exactly one result word on res_o carrying the
// position, last window difference, current and previous time sums, edges still
// to capture and the ready flag (a status read shows the flag before clearing it).
// cfg_i writes the direction inversion bit; it is always ready and should only be
// written while no word is in flight.
// A word accepted into the input register is updated through the engine into the
// result register, which drives res_o.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its word and the
// input register takes one more; req_i.ready then drops until res_o drains.
// Reset clears all counters, sums, flags and the inversion bit, and empties both
// registers.
`include "quadrature_speed_capture_core_defines.svh"
module quadrature_speed_capture_core
  import qsc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  qsc_req_if.sink  req_i,
  qsc_res_if.source res_o,
  qsc_cfg_if.sink  cfg_i
);

  logic s1_valid_q;
  req_t s1_req_q;
  logic out_valid_q;
  res_t out_res_q;
  logic invert_q;
  logic s2_free;
  logic fire;
  res_t engine_res;

  assign s2_free     = !out_valid_q || res_o.ready;
  assign fire        = s1_valid_q && s2_free;
  assign req_i.ready = !s1_valid_q || s2_free;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
    end else if (cfg_i.valid) begin
      invert_q <= cfg_i.invert_direction;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (s2_free) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_req_q.req_type       <= req_i.req_type;
      s1_req_q.edge_timestamp <= req_i.edge_timestamp;
      s1_req_q.level_a        <= req_i.level_a;
      s1_req_q.level_b        <= req_i.level_b;
    end
  end

  qsc_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire),
    .req_i    (s1_req_q),
    .invert_i (invert_q),
    .result_o (engine_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= engine_res;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.position          = out_res_q.position;
  assign res_o.pulse_difference  = out_res_q.pulse_difference;
  assign res_o.current_time_sum  = out_res_q.current_time_sum;
  assign res_o.previous_time_sum = out_res_q.previous_time_sum;
  assign res_o.edges_remaining   = out_res_q.edges_remaining;
  assign res_o.data_ready        = out_res_q.data_ready;

  `QSC_ASSERT_NEXT(a_s1_held, clk_i, rst_ni, s1_valid_q && !s2_free, s1_valid_q, "held word lost")
  `QSC_ASSERT_SAME(a_no_overrun, clk_i, rst_ni, req_i.valid && req_i.ready && s1_valid_q, s2_free, "input register overrun")
  `QSC_ASSERT_SAME(a_edges_range, clk_i, rst_ni, out_valid_q, out_res_q.edges_remaining <= WINDOW_EDGES_C, "edge count out of range")

endmodule

@@ bench/quadrature_speed_capture_core_tb.sv @@
// Self-checking bench for the quadrature speed capture core: every result word is predicted and compared.
`timescale 1ns / 100ps
module quadrature_speed_capture_core_tb;
  import qsc_pkg::*;

  logic clk;
  logic rst_n;

  qsc_req_if req_ch ();
  qsc_res_if res_ch ();
  qsc_cfg_if cfg_ch ();

  quadrature_speed_capture_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  // Predicted state of the capture logic.
  logic        pr_invert;
  logic [7:0]  pr_overflows;
  logic [31:0] pr_position;
  logic [31:0] pr_window_start;
  logic [31:0] pr_difference;
  logic [5:0]  pr_edges_left;
  logic        pr_ready;
  logic [31:0] pr_time_sum;
  logic [31:0] pr_prev_time_sum;

  res_t        expected_words[$];
  int unsigned error_count;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // Advances the predicted state by one request word and returns the result word.
  function automatic res_t capture_step(input req_t word);
    res_t  result;
    logic  shown_ready;
    logic  count_up;
    case (req_type_e'(word.req_type))
      REQ_OVERFLOW: begin
        pr_overflows = pr_overflows + 8'd1;
        if (pr_overflows[4:0] == 5'd0) begin
          if (pr_overflows == 8'd0) pr_time_sum = pr_time_sum - WRAP_CORRECTION;
          pr_difference    = pr_position - pr_window_start;
          pr_window_start  = pr_position;
          pr_edges_left    = WINDOW_EDGES_C;
          pr_prev_time_sum = pr_time_sum;
          pr_time_sum      = '0;
        end
        // A window still short of edges when the period runs out is abandoned.
        if (pr_overflows[4:0] == PERIOD_MASK && pr_edges_left != '0) begin
          pr_edges_left = '0;
          pr_time_sum   = '0;
          pr_ready      = 1'b1;
        end
      end
      REQ_EDGE_A, REQ_EDGE_B: begin
        if (pr_edges_left != '0) begin
          pr_time_sum   = pr_time_sum + {8'd0, pr_overflows, word.edge_timestamp};
          pr_edges_left = pr_edges_left - 6'd1;
          if (pr_edges_left == '0) pr_ready = 1'b1;
        end
        count_up = ((word.level_a == word.level_b) == (word.req_type == REQ_EDGE_B)) ^ pr_invert;
        pr_position = count_up ? pr_position + 32'd1 : pr_position - 32'd1;
      end
      default: ;
    endcase
    shown_ready = pr_ready;
    if (word.req_type == REQ_STATUS) pr_ready = 1'b0;
    result.position          = pr_position;
    result.pulse_difference  = pr_difference;
    result.current_time_sum  = pr_time_sum;
    result.previous_time_sum = pr_prev_time_sum;
    result.edges_remaining   = pr_edges_left;
    result.data_ready        = shown_ready;
    return result;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_checker
    res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_words.size() == 0) begin
        error_count++;
        $display("%0t ns: result word with none expected, position 0x%08h", $time,
                 res_ch.position);
      end else begin
        want = expected_words.pop_front();
        check_field("position", want.position, res_ch.position);
        check_field("pulse_difference", want.pulse_difference, res_ch.pulse_difference);
        check_field("current_time_sum", want.current_time_sum, res_ch.current_time_sum);
        check_field("previous_time_sum", want.previous_time_sum, res_ch.previous_time_sum);
        check_field("edges_remaining", 32'(want.edges_remaining), 32'(res_ch.edges_remaining));
        check_field("data_ready", 32'(want.data_ready), 32'(res_ch.data_ready));
      end
    end
  end

  // The receiver stalls at random; a zero percentage gives a clean stretch.
  always @(negedge clk)
    res_ch.ready = ($urandom_range(99) >= rx_stall_pct);

  task automatic send_word(input req_type_e kind, input logic [15:0] stamp,
                           input logic lvl_a, input logic lvl_b);
    req_t word;
    word.req_type       = kind;
    word.edge_timestamp = stamp;
    word.level_a        = lvl_a;
    word.level_b        = lvl_b;
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid          = 1'b1;
    req_ch.req_type       = word.req_type;
    req_ch.edge_timestamp = word.edge_timestamp;
    req_ch.level_a        = word.level_a;
    req_ch.level_b        = word.level_b;
    forever begin
      @(posedge clk);
      if (req_ch.ready) break;
    end
    expected_words.push_back(capture_step(word));
  endtask

  task automatic send_random_edge();
    logic [15:0] stamp;
    case ($urandom_range(3))
      0:       stamp = 16'h0000;
      1:       stamp = 16'hFFFF;
      default: stamp = 16'($urandom);
    endcase
    send_word($urandom_range(1) ? REQ_EDGE_B : REQ_EDGE_A, stamp, 1'($urandom), 1'($urandom));
  endtask

  task automatic send_filler(input req_type_e kind);
    send_word(kind, 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Stops sending and waits until every outstanding word has come back.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (expected_words.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      error_count++;
      $display("%0t ns: %0d result words never arrived", $time, expected_words.size());
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_direction(input logic invert);
    drain_results();
    @(negedge clk);
    cfg_ch.valid            = 1'b1;
    cfg_ch.invert_direction = invert;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    pr_invert = invert;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Every request kind, all four level combinations per channel and the timestamp extremes.
  task automatic test_directed_ops();
    send_word(REQ_STATUS, 16'h0000, 1'b0, 1'b0);
    send_word(REQ_EDGE_A, 16'h0000, 1'b0, 1'b0);
    send_word(REQ_EDGE_A, 16'hFFFF, 1'b0, 1'b1);
    send_word(REQ_EDGE_A, 16'h0000, 1'b1, 1'b0);
    send_word(REQ_EDGE_A, 16'hFFFF, 1'b1, 1'b1);
    send_word(REQ_EDGE_B, 16'h0000, 1'b0, 1'b0);
    send_word(REQ_EDGE_B, 16'hFFFF, 1'b0, 1'b1);
    send_word(REQ_EDGE_B, 16'h0000, 1'b1, 1'b0);
    send_word(REQ_EDGE_B, 16'hFFFF, 1'b1, 1'b1);
    send_word(REQ_OVERFLOW, 16'hFFFF, 1'b1, 1'b1);
    send_word(REQ_STATUS, 16'hFFFF, 1'b1, 1'b1);
  endtask

  // Whole timer periods of 32 ticks. Dense periods finish their window before the
  // cancel point; sparse ones are cancelled. A run of eight periods passes the counter wrap.
  task automatic test_windows(input int periods, input bit steady);
    bit dense;
    int n_edges;
    if (steady) begin
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
    end
    for (int p = 0; p < periods; p++) begin
      dense = ($urandom_range(2) != 0);
      for (int t = 0; t < 32; t++) begin
        n_edges = dense ? $urandom_range(3) : $urandom_range(1);
        repeat (n_edges) begin
          if ($urandom_range(99) < 8) send_filler(REQ_STATUS);
          else send_random_edge();
        end
        send_filler(REQ_OVERFLOW);
      end
    end
    tx_idle_pct  = 17;
    rx_stall_pct = 17;
  endtask

  task automatic test_random_mix(input int n_words);
    repeat (n_words) begin
      case ($urandom_range(3))
        0:       send_filler(REQ_OVERFLOW);
        1:       send_filler(REQ_STATUS);
        default: send_random_edge();
      endcase
    end
  endtask

  initial begin
    rst_n                   = 1'b0;
    req_ch.valid            = 1'b0;
    req_ch.req_type         = REQ_OVERFLOW;
    req_ch.edge_timestamp   = '0;
    req_ch.level_a          = 1'b0;
    req_ch.level_b          = 1'b0;
    res_ch.ready            = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.invert_direction = 1'b0;
    error_count             = 0;
    tx_idle_pct             = 17;
    rx_stall_pct            = 17;
    pr_invert               = 1'b0;
    pr_overflows            = '0;
    pr_position             = '0;
    pr_window_start         = '0;
    pr_difference           = '0;
    pr_edges_left           = '0;
    pr_ready                = 1'b0;
    pr_time_sum             = '0;
    pr_prev_time_sum        = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    write_direction(1'b0);
    test_directed_ops();
    test_windows(8, 1'b0);
    write_direction(1'b1);
    test_directed_ops();
    test_windows(3, 1'b0);
    test_windows(4, 1'b1);
    write_direction(1'b0);
    test_random_mix(250);
    write_direction(1'b1);
    test_windows(4, 1'b0);
    write_direction(1'b0);
    test_windows(4, 1'b0);
    drain_results();

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
